/* rtl/dtq_pkg.sv */
`default_nettype none

package dtq_pkg;

    localparam int QUEUE_DEPTH = 17;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int ID_W        = 8;
    localparam int DELAY_W     = 16;
    localparam int TIME_W      = 32;
    localparam int ENT_W       = TIME_W + ID_W;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_ADD_OK  = 2'd0,
        K_FIRED   = 2'd1,
        K_NONE    = 2'd2,
        K_FULL    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_TICK,
        S_LOOP,
        S_SCAN,
        S_DRAIN,
        S_CHECK,
        S_MOVE,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic add_exec;
        logic tick_start;
        logic scan_rst;
        logic scan_issue;
        logic move_rd;
        logic move_wr;
        logic final_emit;
    } t_dtq_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic reached;
        logic out_free;
    } t_dtq_sts;

endpackage

`default_nettype wire

/* rtl/dtq_ram.sv */
`default_nettype none

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/dtq_ctrl.sv */
`default_nettype none

module dtq_ctrl
    import dtq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_op,
    input  wire t_dtq_sts i_sts,
    output t_dtq_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_op'(i_in_op) == OP_TICK) ? S_TICK : S_ADD;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK:  n_state = S_LOOP;
            S_LOOP:  n_state = i_sts.count_zero ? S_FINAL : S_SCAN;
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_CHECK;
            S_CHECK: begin
                if (!i_sts.reached) begin
                    n_state = S_FINAL;
                end else if (i_sts.out_free) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE:  n_state = S_LOOP;
            S_FINAL: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
            end
            S_ADD:   o_cmd.add_exec   = i_sts.out_free;
            S_TICK:  o_cmd.tick_start = 1'b1;
            S_LOOP:  o_cmd.scan_rst   = 1'b1;
            S_SCAN:  o_cmd.scan_issue = 1'b1;
            S_DRAIN: o_cmd = '0;
            S_CHECK: o_cmd.move_rd    = i_sts.reached & i_sts.out_free;
            S_MOVE:  o_cmd.move_wr    = 1'b1;
            S_FINAL: o_cmd.final_emit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dtq_datapath.sv */
`default_nettype none

module dtq_datapath
    import dtq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dtq_cmd           i_cmd,
    input  wire logic [ID_W-1:0]    i_in_id,
    input  wire logic [DELAY_W-1:0] i_in_delay,
    input  wire logic               i_out_ready,
    output t_dtq_sts                o_sts,
    output logic                    o_out_valid,
    output logic [1:0]              o_out_kind,
    output logic [ID_W-1:0]         o_out_id,
    output logic [TIME_W-1:0]       o_out_due,
    output logic                    o_out_last
);

    logic [TIME_W-1:0]  r_now;
    logic [CNT_W-1:0]   r_count;
    logic [ID_W-1:0]    r_in_id;
    logic [DELAY_W-1:0] r_in_delay;

    logic [IDX_W-1:0]   r_scan;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;

    logic [IDX_W-1:0]   r_best_idx;
    logic [ID_W-1:0]    r_best_id;
    logic [TIME_W-1:0]  r_best_due;

    logic               r_pend_vld;
    logic [ID_W-1:0]    r_pend_id;
    logic [TIME_W-1:0]  r_pend_due;

    logic               r_out_vld;
    t_kind              r_out_kind;
    logic [ID_W-1:0]    r_out_id;
    logic [TIME_W-1:0]  r_out_due;
    logic               r_out_last;

    logic [CNT_W-1:0]   count_dec;
    logic               full;
    logic [TIME_W-1:0]  add_due;
    logic [ENT_W-1:0]   rdata;
    logic [ID_W-1:0]    rd_id;
    logic [TIME_W-1:0]  rd_due;
    logic [TIME_W-1:0]  diff;
    logic               take;
    logic               out_free;
    logic               out_load;
    t_kind              out_kind;
    logic [ID_W-1:0]    out_id;
    logic [TIME_W-1:0]  out_due;
    logic               out_last;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENT_W-1:0]   wdata;
    logic [IDX_W-1:0]   raddr;
    logic [TIME_W-1:0]  slack;

    assign count_dec = r_count - CNT_W'(1);
    assign full      = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign add_due   = r_now + TIME_W'(r_in_delay);
    assign rd_id     = rdata[ID_W-1:0];
    assign rd_due    = rdata[ENT_W-1:ID_W];
    assign out_free  = !r_out_vld || i_out_ready;

    // wrap-safe ordering: earlier deadline wins, ties go to the lower id
    assign diff = rd_due - r_best_due;
    assign take = r_rd_vld && ((r_rd_idx == '0) ||
                  ((diff == '0) ? (rd_id < r_best_id) : diff[TIME_W-1]));

    assign slack = r_now - r_best_due;

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.scan_last  = (CNT_W'(r_scan) == count_dec);
    assign o_sts.reached    = !slack[TIME_W-1];
    assign o_sts.out_free   = out_free;

    // queue storage: scan reads walk the entries, a removal refills the hole from the tail
    assign raddr = i_cmd.move_rd ? count_dec[IDX_W-1:0] : r_scan;
    assign we    = (i_cmd.add_exec && !full) || i_cmd.move_wr;
    assign waddr = i_cmd.move_wr ? r_best_idx : r_count[IDX_W-1:0];
    assign wdata = i_cmd.move_wr ? rdata : {add_due, r_in_id};

    dtq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result word selection
    always_comb begin
        out_load = 1'b0;
        out_kind = K_NONE;
        out_id   = '0;
        out_due  = '0;
        out_last = 1'b1;
        priority if (i_cmd.add_exec) begin
            out_load = 1'b1;
            if (full) begin
                out_kind = K_FULL;
            end else begin
                out_kind = K_ADD_OK;
                out_id   = r_in_id;
                out_due  = add_due;
            end
        end else if (i_cmd.move_rd) begin
            out_load = r_pend_vld;
            out_kind = K_FIRED;
            out_id   = r_pend_id;
            out_due  = r_pend_due;
            out_last = 1'b0;
        end else if (i_cmd.final_emit) begin
            out_load = 1'b1;
            if (r_pend_vld) begin
                out_kind = K_FIRED;
                out_id   = r_pend_id;
                out_due  = r_pend_due;
            end
        end else begin
            out_load = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.tick_start) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.add_exec && !full) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.move_rd) begin
                r_count <= count_dec;
            end
            if (i_cmd.tick_start) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.move_rd) begin
                r_pend_vld <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_id    <= i_in_id;
            r_in_delay <= i_in_delay;
        end
        if (i_cmd.scan_rst) begin
            r_scan <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan <= r_scan + IDX_W'(1);
        end
        r_rd_idx <= r_scan;
        if (take) begin
            r_best_idx <= r_rd_idx;
            r_best_id  <= rd_id;
            r_best_due <= rd_due;
        end
        if (i_cmd.move_rd) begin
            r_pend_id  <= r_best_id;
            r_pend_due <= r_best_due;
        end
        if (out_load) begin
            r_out_kind <= out_kind;
            r_out_id   <= out_id;
            r_out_due  <= out_due;
            r_out_last <= out_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_kind  = r_out_kind;
    assign o_out_id    = r_out_id;
    assign o_out_due   = r_out_due;
    assign o_out_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        ((r_count == $past(r_count) + CNT_W'(1)) ||
         (r_count == $past(r_count) - CNT_W'(1))))
        else $error("queue count moved by more than one");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (out_kind == K_FULL)) |-> (r_count == CNT_W'(QUEUE_DEPTH)))
        else $error("add rejected while queue has room");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && ((r_out_kind == K_NONE) || (r_out_kind == K_FULL))) |->
        ((r_out_id == '0) && (r_out_due == '0) && r_out_last))
        else $error("status word carries task fields");
`endif

endmodule

`default_nettype wire

/* rtl/deadline_timer_queue_core.sv */
`default_nettype none

// Channel   Direction  tuser                    tdata                                tlast
// s_axis    in         [0] operation            [7:0] task_id, [23:8] delay_ticks    -
// m_axis    out        [1:0] kind               [7:0] fired_id, [39:8] due_time      last
//
// One word in flight at a time. An add is accepted in the idle state; its result is
// registered in the add state once the output register is free. A tick is accepted,
// steps the time counter, then runs passes: each scans the queue for the earliest
// deadline and, if it is due, removes it and emits the previously fired task. A pass
// that finds nothing due, or an empty queue, ends the tick with the final emit. The
// linear minimum search over the single-read-port queue RAM sets the pass length.
// Reset (synchronous, active low) zeroes the time counter and empties the queue.
// A stalled result holds in the output register; the next word is still taken meanwhile.

module deadline_timer_queue_core
    import dtq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [7:0] task_id, [23:8] delay_ticks
    input  wire logic        i_s_axis_tuser,   // [0] operation

    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata,   // [7:0] fired_id, [39:8] due_time
    output logic      [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic             o_m_axis_tlast
);

    t_dtq_cmd          cmd;
    t_dtq_sts          sts;
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_due;

    // sequence the add, scan, remove and emit steps
    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // time counter, queue RAM, best-entry search and result register
    dtq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_id     (i_s_axis_tdata[ID_W-1:0]),
        .i_in_delay  (i_s_axis_tdata[ID_W +: DELAY_W]),
        .i_out_ready (i_m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_id    (out_id),
        .o_out_due   (out_due),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = cmd.in_ready;
    assign o_m_axis_tdata  = {out_due, out_id};

endmodule

`default_nettype wire

/* bench/tb_deadline_timer_queue_core.sv */
module tb_deadline_timer_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    // One input word: add (task id, delay) or a tick.
    typedef struct packed {
        t_op         op;
        logic [7:0]  task_id;
        logic [15:0] delay;
    } t_timer_req;

    // One output word as the block should present it.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  task_id;
        logic [31:0] due;
        logic        last;
    } t_timer_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;   // [7:0] task_id, [23:8] delay_ticks
    logic        i_s_axis_tuser = 1'b0; // [0] operation

    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [7:0] fired_id, [39:8] due_time
    logic [1:0]  o_m_axis_tuser;        // [1:0] kind
    logic        o_m_axis_tlast;

    deadline_timer_queue_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Words waiting to be driven, and events the timer must still report.
    t_timer_req   req_q[$];
    t_timer_event due_events_q[$];

    int req_total;
    int req_taken;
    int mismatches;

    // Shadow copy of the timer: time counter and the unordered deadline store.
    logic [31:0] now_ticks;
    logic [7:0]  slot_id [QUEUE_DEPTH];
    logic [31:0] slot_due [QUEUE_DEPTH];
    int          slot_fill;

    // Handshake seen at the last rising edge, read by the driver at the falling edge.
    bit word_in_taken;

    int send_gap;
    int stall_left;
    bit calm;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones; now and then flip into a calm stretch
    // with no idling at all on either side.
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 63) == 0) begin
            calm = !calm;
        end
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Deadline order: wrap-safe signed difference, ties go to the lower task id.
    function automatic bit fires_first(int a, int b);
        logic [31:0] diff;
        diff = slot_due[a] - slot_due[b];
        if (diff == 32'd0) begin
            return slot_id[a] < slot_id[b];
        end
        return diff[31];
    endfunction

    // Apply one accepted word to the shadow timer and queue the events it causes.
    function automatic void advance_timer(t_timer_req req);
        t_timer_event ev;
        t_timer_event held;
        logic [31:0]  lag;
        int           fired;
        int           best;
        if (req.op == OP_ADD) begin
            if (slot_fill >= QUEUE_DEPTH) begin
                ev = '{kind: K_FULL, task_id: 8'd0, due: 32'd0, last: 1'b1};
            end else begin
                slot_id[slot_fill]  = req.task_id;
                slot_due[slot_fill] = now_ticks + 32'(req.delay);
                ev = '{kind: K_ADD_OK, task_id: req.task_id,
                       due: slot_due[slot_fill], last: 1'b1};
                slot_fill++;
            end
            due_events_q.push_back(ev);
            return;
        end
        now_ticks = now_ticks + 32'd1;
        fired = 0;
        while (slot_fill > 0 && fired < QUEUE_DEPTH) begin
            best = 0;
            for (int i = 1; i < slot_fill; i++) begin
                if (fires_first(i, best)) begin
                    best = i;
                end
            end
            lag = now_ticks - slot_due[best];
            if (lag[31]) begin
                break;
            end
            // Hold each fired event back one step so the final one can take last.
            if (fired > 0) begin
                due_events_q.push_back(held);
            end
            held = '{kind: K_FIRED, task_id: slot_id[best], due: slot_due[best], last: 1'b0};
            fired++;
            slot_fill--;
            slot_id[best]  = slot_id[slot_fill];
            slot_due[best] = slot_due[slot_fill];
        end
        if (fired == 0) begin
            held = '{kind: K_NONE, task_id: 8'd0, due: 32'd0, last: 1'b0};
        end
        held.last = 1'b1;
        due_events_q.push_back(held);
    endfunction

    function automatic void push_add(logic [7:0] task_id, logic [15:0] delay);
        req_q.push_back('{op: OP_ADD, task_id: task_id, delay: delay});
        req_total++;
    endfunction

    // Ticks carry random payload bits; the block must ignore them.
    function automatic void push_tick();
        req_q.push_back('{op: OP_TICK, task_id: 8'($urandom), delay: 16'($urandom)});
        req_total++;
    endfunction

    // Lean on a handful of ids so duplicates and id tie-breaks show up often.
    function automatic logic [7:0] rand_task_id();
        int pick;
        if ($urandom_range(0, 9) < 3) begin
            pick = $urandom_range(0, 4);
            return (pick == 4) ? 8'd255 : 8'(pick);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Short delays keep the store draining; a rare full-range delay parks an
    // entry that will outlive the run.
    function automatic logic [15:0] rand_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return 16'($urandom_range(0, 4));
        end else if (r < 99) begin
            return 16'($urandom_range(5, 60));
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Drive the input stream at the falling edge: hold a word until it is taken,
    // then idle for the chosen gap before offering the next one.
    always @(negedge i_clk) begin
        t_timer_req req;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || word_in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    req = req_q.pop_front();
                    i_s_axis_tuser  <= req.op;
                    i_s_axis_tdata  <= {req.delay, req.task_id};
                    i_s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Throttle the output stream: random stalls of random length.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Sample both streams at the rising edge. Check the output word first so a
    // word leaving in the same cycle can never match the item just taken.
    always @(posedge i_clk) begin
        t_timer_event want;
        t_timer_event got;
        word_in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{kind: t_kind'(o_m_axis_tuser), task_id: o_m_axis_tdata[7:0],
                        due: o_m_axis_tdata[39:8], last: o_m_axis_tlast};
                if (due_events_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected word kind=%0d id=%0d due=%0d last=%0b",
                                 $realtime, got.kind, got.task_id, got.due, got.last);
                    end
                end else begin
                    want = due_events_q.pop_front();
                    if (got.kind !== want.kind || got.task_id !== want.task_id ||
                        got.due !== want.due || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch expected kind=%0d id=%0d due=%0d last=%0b",
                                     $realtime, want.kind, want.task_id, want.due, want.last);
                            $display("%0t:          actual   kind=%0d id=%0d due=%0d last=%0b",
                                     $realtime, got.kind, got.task_id, got.due, got.last);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                word_in_taken = 1'b1;
                req_taken++;
                advance_timer('{op: t_op'(i_s_axis_tuser), task_id: i_s_axis_tdata[7:0],
                                delay: i_s_axis_tdata[23:8]});
            end
        end
    end

    initial begin
        int kind_pick;
        int burst;
        now_ticks  = 32'd0;
        slot_fill  = 0;
        req_total  = 0;
        req_taken  = 0;
        mismatches = 0;
        send_gap   = 0;
        stall_left = 0;
        calm       = 1'b0;

        // Directed: zero delay fires on the first tick, a full-range delay
        // parks for good, then a tick with nothing due.
        push_add(8'd0, 16'd0);
        push_add(8'd255, 16'hFFFF);
        push_tick();
        push_tick();
        // Duplicate ids and an equal deadline: lower id first, twins both fire.
        push_add(8'd7, 16'd1);
        push_add(8'd7, 16'd1);
        push_add(8'd3, 16'd1);
        push_tick();
        // Fill the store behind the parked entry, overflow once, then fire
        // sixteen equal deadlines in one tick ordered by id.
        for (int i = 15; i >= 0; i--) begin
            push_add(8'(i), 16'd0);
        end
        push_add(8'd42, 16'd1);
        push_tick();

        // Random: mostly add bursts followed by ticks, some fill-and-overflow
        // runs, lone ticks and lone adds as noise.
        while (req_total < 450) begin
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 50) begin
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++) begin
                    push_add(rand_task_id(), rand_delay());
                end
                burst = $urandom_range(1, 5);
                for (int i = 0; i < burst; i++) begin
                    push_tick();
                end
            end else if (kind_pick < 62) begin
                for (int i = 0; i < 18; i++) begin
                    push_add(rand_task_id(), 16'($urandom_range(0, 3)));
                end
                for (int i = 0; i < 6; i++) begin
                    push_tick();
                end
            end else if (kind_pick < 85) begin
                push_tick();
            end else begin
                push_add(rand_task_id(), rand_delay());
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_taken != req_total) begin
            @(posedge i_clk);
        end
        while (due_events_q.size() != 0) begin
            @(posedge i_clk);
        end
        // Leave room for a full tick pass in case a stray word is still coming.
        repeat (500) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/dtq_ctrl.sv
rtl/dtq_datapath.sv
rtl/deadline_timer_queue_core.sv
bench/tb_deadline_timer_queue_core.sv
